### hdl/bole_pkg.sv
// package for the bounded ordered list engine
// request and status codes, sequencer states and shared widths; no dependencies
`default_nettype none

package bole_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int POS_W        = 8;
  localparam int VAL_W        = 32;
  localparam int REQ_W        = 3;
  localparam int ST_W         = 2;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_TAIL = 3'd1,
    REQ_INS_POS  = 3'd2,
    REQ_DEL_HEAD = 3'd3,
    REQ_DEL_TAIL = 3'd4,
    REQ_DEL_POS  = 3'd5,
    REQ_READ_ALL = 3'd6
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD_GO,
    S_MOD,
    S_INS_RD,
    S_INS_WR,
    S_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_RES,
    S_RD_ADDR,
    S_RD_EMIT
  } state_t;

endpackage

`default_nettype wire

### hdl/bounded_ordered_list_engine.sv
// top level of the bounded ordered list engine: sequencer, element memory, result register
// depends on bole_pkg and bole_mod
//
//   group   dir  tdata                         tuser           tlast
//   s_*     in   [7:0] position, [39:8] value  [2:0] req_type  -
//   m_*     out  [31:0] value_out              [1:0] status    last
//
// a request is taken only in idle; the sequencer holds s_tready low until it is done
// insert/delete move one element at a time, a read state then a write state, through the single memory port pair
// positional requests first pass through the remainder unit (one bit per cycle)
// read-out fetches each element in S_RD_ADDR and emits it from S_RD_EMIT, which waits while m_tready holds it back
// rst is synchronous; the element memory needs no clearing, the count resets to zero
`default_nettype none

module bounded_ordered_list_engine #(
  parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bole_pkg::IN_DATA_W-1:0]  s_tdata,   // position, value_in
  input  logic [bole_pkg::REQ_W-1:0]      s_tuser,   // req_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bole_pkg::OUT_DATA_W-1:0] m_tdata,   // value_out
  output logic [bole_pkg::ST_W-1:0]       m_tuser,   // status
  output logic                            m_tlast
);
  import bole_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_t           state, state_next;
  req_t             req, req_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [VAL_W-1:0] val, val_next;
  logic [CW-1:0]    idx, idx_next;
  logic [CW-1:0]    ptr, ptr_next;
  logic [CW-1:0]    cnt, cnt_next;
  status_t          status, status_next;

  logic [CW-1:0]    ptr_dec, ptr_inc;
  logic             slot_free;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata;
  logic             mem_we, mem_re;
  logic [AW-1:0]    waddr, raddr;
  logic [VAL_W-1:0] wdata;

  logic             mod_start, mod_done;
  logic [POS_W-1:0] mod_dividend;
  logic [CW-1:0]    mod_rem;

  logic             out_load;
  logic [VAL_W-1:0] out_value;
  status_t          out_status;
  logic             out_last;

  assign ptr_dec   = ptr - CW'(1);
  assign ptr_inc   = ptr + CW'(1);
  assign slot_free = !m_tvalid || m_tready;

  bole_mod #(.DW(CW)) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (cnt),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // next state
  always_comb begin
    req_t in_req;
    in_req      = req_t'(s_tuser);
    state_next  = state;
    req_next    = req;
    pos_next    = pos;
    val_next    = val;
    idx_next    = idx;
    ptr_next    = ptr;
    cnt_next    = cnt;
    status_next = status;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          req_next    = in_req;
          pos_next    = s_tdata[POS_W-1:0];
          val_next    = s_tdata[POS_W +: VAL_W];
          status_next = ST_OK;
          case (in_req)
            REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
              if (cnt == CW'(CAPACITY)) begin
                status_next = ST_FULL;
                state_next  = S_RES;
              end else if (in_req == REQ_INS_HEAD || cnt == '0 ||
                           (in_req == REQ_INS_POS && s_tdata[POS_W-1:0] == '0)) begin
                idx_next   = '0;
                ptr_next   = cnt;
                state_next = S_INS_RD;
              end else if (in_req == REQ_INS_TAIL) begin
                idx_next   = cnt;
                ptr_next   = cnt;
                state_next = S_INS_RD;
              end else begin
                state_next = S_MOD_GO;
              end
            end
            REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_POS: begin
              if (cnt == '0) begin
                status_next = ST_EMPTY;
                state_next  = S_RES;
              end else if (in_req == REQ_DEL_HEAD) begin
                idx_next   = '0;
                ptr_next   = '0;
                state_next = S_DEL_RD;
              end else if (in_req == REQ_DEL_TAIL) begin
                idx_next   = cnt - CW'(1);
                ptr_next   = cnt - CW'(1);
                state_next = S_DEL_RD;
              end else begin
                state_next = S_MOD_GO;
              end
            end
            REQ_READ_ALL: begin
              if (cnt == '0) begin
                status_next = ST_EMPTY;
                state_next  = S_RES;
              end else begin
                ptr_next   = '0;
                state_next = S_RD_ADDR;
              end
            end
            default: state_next = S_RES;
          endcase
        end
      end
      S_MOD_GO: state_next = S_MOD;
      S_MOD: begin
        if (mod_done) begin
          if (req == REQ_INS_POS) begin
            idx_next   = mod_rem + CW'(1);
            ptr_next   = cnt;
            state_next = S_INS_RD;
          end else begin
            idx_next   = mod_rem;
            ptr_next   = mod_rem;
            state_next = S_DEL_RD;
          end
        end
      end
      S_INS_RD: begin
        if (ptr == idx) begin
          state_next = S_PUT;
        end else begin
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ptr_next   = ptr_dec;
        state_next = S_INS_RD;
      end
      S_PUT: begin
        cnt_next   = cnt + CW'(1);
        state_next = S_RES;
      end
      S_DEL_RD: begin
        if (ptr_inc == cnt) begin
          cnt_next   = cnt - CW'(1);
          state_next = S_RES;
        end else begin
          state_next = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        ptr_next   = ptr_inc;
        state_next = S_DEL_RD;
      end
      S_RES: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_RD_ADDR: state_next = S_RD_EMIT;
      S_RD_EMIT: begin
        if (slot_free) begin
          if (ptr_inc == cnt) begin
            state_next = S_IDLE;
          end else begin
            ptr_next   = ptr_inc;
            state_next = S_RD_ADDR;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready     = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    waddr        = ptr[AW-1:0];
    raddr        = ptr[AW-1:0];
    wdata        = rdata;
    mod_start    = 1'b0;
    mod_dividend = pos;
    out_load     = 1'b0;
    out_value    = '0;
    out_status   = status;
    out_last     = 1'b1;
    case (state)
      S_IDLE: s_tready = 1'b1;
      S_MOD_GO: begin
        mod_start = 1'b1;
        if (req == REQ_INS_POS) begin
          mod_dividend = pos - POS_W'(1);
        end
      end
      S_INS_RD: begin
        mem_re = (ptr != idx);
        raddr  = ptr_dec[AW-1:0];
      end
      S_INS_WR: mem_we = 1'b1;
      S_PUT: begin
        mem_we = 1'b1;
        waddr  = idx[AW-1:0];
        wdata  = val;
      end
      S_DEL_RD: begin
        mem_re = (ptr_inc != cnt);
        raddr  = ptr_inc[AW-1:0];
      end
      S_DEL_WR: mem_we = 1'b1;
      S_RES: out_load = slot_free;
      S_RD_ADDR: mem_re = 1'b1;
      S_RD_EMIT: begin
        out_load   = slot_free;
        out_value  = rdata;
        out_status = ST_OK;
        out_last   = (ptr_inc == cnt);
      end
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    req    <= req_next;
    pos    <= pos_next;
    val    <= val_next;
    idx    <= idx_next;
    ptr    <= ptr_next;
    status <= status_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_value;
      m_tuser <= out_status;
      m_tlast <= out_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && cnt != $past(cnt)) |->
      ($past(state) == S_PUT || $past(state) == S_DEL_RD))
    else $error("element count changed outside insert or delete");

  a_readout_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_EMIT) |-> (ptr < cnt))
    else $error("read-out pointer beyond list");

  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0 && m_tlast))
    else $error("status beat carries data or is not last");

endmodule

`default_nettype wire

### hdl/bole_mod.sv
// iterative remainder unit, one restoring subtract step per cycle
// depends on bole_pkg
`default_nettype none

module bole_mod #(
  parameter int DW = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bole_pkg::POS_W-1:0] dividend,
  input  logic [DW-1:0]             divisor,
  output logic                      done,
  output logic [DW-1:0]             remainder
);
  import bole_pkg::*;

  localparam int SW = $clog2(POS_W);

  logic            busy;
  logic [SW-1:0]   step;
  logic [POS_W-1:0] shreg;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dvs;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic [DW-1:0]   rem_next;

  always_comb begin
    trial = {rem, shreg[POS_W-1]};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      rem_next = diff[DW-1:0];
    end else begin
      rem_next = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        step  <= '0;
        shreg <= dividend;
        rem   <= '0;
        dvs   <= divisor;
      end else if (busy) begin
        rem   <= rem_next;
        shreg <= {shreg[POS_W-2:0], 1'b0};
        step  <= step + SW'(1);
        if (step == SW'(POS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (remainder < dvs))
    else $error("remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("remainder unit restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(rst)) |-> $past(busy))
    else $error("done without a running division");

endmodule

`default_nettype wire

### tb/bole_checker.sv
// checker for the bounded ordered list engine: watches both streams, keeps its own copy
// of the list, predicts every result beat and compares it field by field
// depends on bole_pkg
module bole_checker #(
  parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [bole_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [bole_pkg::REQ_W-1:0]      s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [bole_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic [bole_pkg::ST_W-1:0]       m_tuser,
  input  logic                            m_tlast,
  output int                              errors,
  output int                              pending,
  output int                              beats_checked,
  output int                              full_seen,
  output int                              empty_seen
);
  import bole_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    status_t          status;
    logic             last;
  } list_beat_t;

  logic signed [VAL_W-1:0] list_copy [CAPACITY];
  int                      list_len = 0;
  list_beat_t              expected_beats [$];
  int                      error_total = 0;
  int                      beat_total = 0;
  int                      full_total = 0;
  int                      empty_total = 0;

  function automatic void queue_beat(input logic [VAL_W-1:0] value, input status_t status,
                                     input logic last);
    list_beat_t b;
    b.value  = value;
    b.status = status;
    b.last   = last;
    expected_beats.push_back(b);
  endfunction

  task automatic apply_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                               input logic signed [VAL_W-1:0] value);
    int slot;
    int p;
    int i;
    p = pos;
    case (kind)
      REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
        if (list_len >= CAPACITY) begin
          queue_beat('0, ST_FULL, 1'b1);
          full_total++;
        end else begin
          if (kind == REQ_INS_HEAD || list_len == 0 || (kind == REQ_INS_POS && p == 0))
            slot = 0;
          else if (kind == REQ_INS_TAIL)
            slot = list_len;
          else
            slot = ((p - 1) % list_len) + 1;
          for (i = list_len; i > slot; i--)
            list_copy[i] = list_copy[i-1];
          list_copy[slot] = value;
          list_len++;
          queue_beat('0, ST_OK, 1'b1);
        end
      end
      REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_POS: begin
        if (list_len == 0) begin
          queue_beat('0, ST_EMPTY, 1'b1);
          empty_total++;
        end else begin
          if (kind == REQ_DEL_HEAD)
            slot = 0;
          else if (kind == REQ_DEL_TAIL)
            slot = list_len - 1;
          else
            slot = p % list_len;
          for (i = slot; i + 1 < list_len; i++)
            list_copy[i] = list_copy[i+1];
          list_len--;
          queue_beat('0, ST_OK, 1'b1);
        end
      end
      REQ_READ_ALL: begin
        if (list_len == 0) begin
          queue_beat('0, ST_EMPTY, 1'b1);
          empty_total++;
        end else begin
          for (i = 0; i < list_len; i++)
            queue_beat(list_copy[i], ST_OK, i + 1 == list_len);
        end
      end
      default: begin
        queue_beat('0, ST_OK, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    list_beat_t got;
    list_beat_t want;
    logic       bad;
    if (rst) begin
      list_len = 0;
    end else begin
      // result side first: a beat here always belongs to an earlier request
      if (m_tvalid && m_tready) begin
        got.value  = m_tdata;
        got.status = status_t'(m_tuser);
        got.last   = m_tlast;
        beat_total++;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got value %h status %0d last %b",
                   $time, got.value, got.status, got.last);
          error_total++;
        end else begin
          want = expected_beats.pop_front();
          bad  = 1'b0;
          if (got.value !== want.value) begin
            $display("%0t: value_out expected %h got %h", $time, want.value, got.value);
            bad = 1'b1;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            bad = 1'b1;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %b got %b", $time, want.last, got.last);
            bad = 1'b1;
          end
          if (bad)
            error_total++;
        end
      end
      if (s_tvalid && s_tready)
        apply_request(s_tuser, s_tdata[POS_W-1:0], s_tdata[POS_W +: VAL_W]);
    end
    errors        <= error_total;
    pending       <= expected_beats.size();
    beats_checked <= beat_total;
    full_seen     <= full_total;
    empty_seen    <= empty_total;
  end

endmodule

### tb/testbench.sv
// top of the bounded ordered list engine bench: clock, reset, request stream in bursts,
// result stream with its own stall pattern, verdict
// depends on bole_pkg, bole_checker and the engine itself
module testbench;
  import bole_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
  localparam int NUM_RANDOM  = 430;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 64;
  localparam logic [15:0] STALL_MASK = 16'b1011_0010_1110_0101;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [REQ_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [ST_W-1:0]       m_tuser;
  logic                  m_tlast;

  int errors;
  int pending;
  int beats_checked;
  int full_seen;
  int empty_seen;
  int cycles = 0;
  int burst_left = 0;
  int sent_by_kind [8];

  bounded_ordered_list_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  bole_checker i_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .errors        (errors),
    .pending       (pending),
    .beats_checked (beats_checked),
    .full_seen     (full_seen),
    .empty_seen    (empty_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d result beats outstanding", cycles, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: free-running, random, fixed mask and heavy stall phases in turn
  always @(posedge clk) begin
    case (cycles[11:10])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 9) < 7);
      2'd2: m_tready <= STALL_MASK[cycles[3:0]];
      default: m_tready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {value, pos};
    sent_by_kind[kind]++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    logic [REQ_W-1:0] kind;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
    int               roll;
    bit               grow;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list answers, then the repairs around head and tail
    send_request(REQ_READ_ALL, 8'd0,   32'h0);
    send_request(REQ_DEL_HEAD, 8'd0,   32'h0);
    send_request(REQ_DEL_TAIL, 8'd0,   32'h0);
    send_request(REQ_DEL_POS,  8'd255, 32'h0);
    send_request(REQ_INS_POS,  8'd200, 32'h7FFF_FFFF);
    send_request(REQ_DEL_TAIL, 8'd0,   32'h0);
    send_request(REQ_INS_HEAD, 8'd0,   32'h8000_0000);
    send_request(REQ_INS_TAIL, 8'd0,   32'h7FFF_FFFF);
    send_request(REQ_INS_POS,  8'd0,   32'hFFFF_FFFF);
    send_request(REQ_INS_POS,  8'd255, 32'h0);
    send_request(REQ_INS_POS,  8'd1,   32'h5555_5555);
    send_request(REQ_INS_POS,  8'd3,   32'hAAAA_AAAA);
    send_request(REQ_READ_ALL, 8'd0,   32'h0);
    send_request(REQ_DEL_POS,  8'd0,   32'h0);
    send_request(REQ_DEL_POS,  8'd5,   32'h0);
    send_request(REQ_DEL_POS,  8'd254, 32'h0);
    send_request(REQ_UNUSED,   8'd255, 32'hFFFF_FFFF);
    send_request(REQ_READ_ALL, 8'd0,   32'h0);
    send_request(REQ_DEL_HEAD, 8'd0,   32'h0);
    send_request(REQ_DEL_TAIL, 8'd0,   32'h0);
    send_request(REQ_READ_ALL, 8'd0,   32'h0);

    // alternate growing and shrinking stretches so full and empty are both reached often
    for (int n = 0; n < NUM_RANDOM; n++) begin
      grow = ((n / 40) % 2) == 0;
      roll = $urandom_range(0, 99);
      if (roll < 10)
        kind = REQ_READ_ALL;
      else if (roll < 12)
        kind = REQ_UNUSED;
      else if (roll < (grow ? 82 : 32))
        kind = REQ_W'(REQ_INS_HEAD + $urandom_range(0, 2));
      else
        kind = REQ_W'(REQ_DEL_HEAD + $urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0: pos = POS_W'($urandom_range(0, 3));
        1: pos = POS_W'($urandom_range(0, 20));
        default: pos = POS_W'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 7))
        0: value = 32'h8000_0000;
        1: value = 32'h7FFF_FFFF;
        2: value = 32'h0;
        3: value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      send_request(kind, pos, value);
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d inserts, %0d deletes, %0d read-outs, %0d unused codes; %0d beats checked",
             sent_by_kind[REQ_INS_HEAD] + sent_by_kind[REQ_INS_TAIL] + sent_by_kind[REQ_INS_POS],
             sent_by_kind[REQ_DEL_HEAD] + sent_by_kind[REQ_DEL_TAIL] + sent_by_kind[REQ_DEL_POS],
             sent_by_kind[REQ_READ_ALL], sent_by_kind[REQ_UNUSED], beats_checked);
    $display("full-list refusals %0d, empty-list answers %0d", full_seen, empty_seen);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
